[design/tdp_pkg.sv]
package tdp_pkg;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_STEP  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Status from the remainder unit back to the controller.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_status_t;

  localparam int SMALL_PRIME   = 3;
  localparam int FIRST_DIVISOR = 5;
  localparam int PAIR_GAP      = 2;
  localparam int WHEEL_STEP    = 6;
  // (d + 6)^2 - d^2 = 12 d + 36
  localparam int SQ_STEP_CONST = WHEEL_STEP * WHEEL_STEP;

endpackage

[design/tdp_div.sv]
module tdp_div #(
  parameter int NUMBER_WIDTH  = 20,
  parameter int DIVISOR_WIDTH = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUMBER_WIDTH-1:0]    dividend,
  input  logic [DIVISOR_WIDTH-1:0]   divisor,
  output tdp_pkg::div_status_t       status
);
  import tdp_pkg::*;

  localparam int CNT_WIDTH = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0]  shreg;
  logic [DIVISOR_WIDTH-1:0] dvs;
  logic [DIVISOR_WIDTH-1:0] rem;
  logic [CNT_WIDTH-1:0]     cnt;
  logic                     busy;
  logic                     done;

  logic [DIVISOR_WIDTH:0]   trial;
  logic                     fits;

  // Restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial = {rem, shreg[NUMBER_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(NUMBER_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[NUMBER_WIDTH-2:0], 1'b0};
      if (fits) begin
        rem <= DIVISOR_WIDTH'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIVISOR_WIDTH-1:0];
      end
    end
  end

  assign status.busy     = busy;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

[design/trial_division_prime_test_unit.sv]
// Trial-division primality tester on the 6k +/- 1 wheel. Each request carries one unsigned
// candidate; the block answers with one is_prime bit (1 for prime). 0 and 1 are not prime, 2
// and 3 are prime, other even numbers are rejected at once; any other candidate is reduced
// modulo 3 and then modulo d and d + 2 for d = 5, 11, 17, ... while d * d <= candidate. All
// remainders come from one shared bit-serial restoring divider that consumes one candidate bit
// per cycle. The trivial cases skip the divider; a candidate that needs k divisor pairs takes
// one division by 3 and then up to 2 * k divisions, and a 20-bit prime near the top of the range
// needs about 170 pairs. One request is in flight at a time; the result sits in an output
// register, so the next request is taken while an earlier result still waits for out_ready.
module trial_division_prime_test_unit #(
  parameter int NUMBER_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [NUMBER_WIDTH-1:0] candidate,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    is_prime
);
  import tdp_pkg::*;

  // Divisors stay below sqrt(2^NUMBER_WIDTH) + a wheel step; the square track gets headroom
  // for one overshoot past the candidate.
  localparam int DW = NUMBER_WIDTH / 2 + 4;
  localparam int SW = NUMBER_WIDTH + 8;

  state_t                  state;
  logic [NUMBER_WIDTH-1:0] n;        // candidate under test
  logic [DW-1:0]           d;        // low divisor of the current pair
  logic [SW-1:0]           sq;       // d * d, tracked incrementally
  logic                    three_phase;
  logic                    hi_phase;
  logic                    verdict;

  logic                    div_start;
  logic [NUMBER_WIDTH-1:0] div_dividend;
  logic [DW-1:0]           div_divisor;
  div_status_t             div_st;

  logic                    in_fire;
  logic                    out_free;
  logic                    sq_over;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign sq_over  = (sq > SW'(n));

  // Divisor select: 3 when a request arrives, d from the bound check, d + 2 when the low
  // divisor of the pair has just cleared.
  always_comb begin
    div_dividend = (state == S_IDLE) ? candidate : n;
    if (state == S_DIV) begin
      div_divisor = d + DW'(PAIR_GAP);
    end else if (state == S_CHECK) begin
      div_divisor = d;
    end else begin
      div_divisor = DW'(SMALL_PRIME);
    end
  end

  // Start the divider: on arrival of a large odd candidate, from the bound check, and
  // back to back for the high divisor of a pair.
  always_comb begin
    div_start = 1'b0;
    unique case (state)
      S_IDLE:  div_start = in_fire && (candidate > NUMBER_WIDTH'(SMALL_PRIME)) && candidate[0];
      S_CHECK: div_start = !sq_over;
      S_DIV:   div_start = div_st.done && !div_st.rem_zero && !three_phase && !hi_phase;
      S_STEP:  div_start = 1'b0;
      S_DONE:  div_start = 1'b0;
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      three_phase <= 1'b0;
      hi_phase    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            // 0 and 1 fail, 2 and 3 pass, other evens fail without a division.
            if (candidate <= NUMBER_WIDTH'(SMALL_PRIME) || !candidate[0]) begin
              state <= S_DONE;
            end else begin
              state       <= S_DIV;
              three_phase <= 1'b1;
              hi_phase    <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            if (div_st.rem_zero) begin
              state <= S_DONE;
            end else if (three_phase) begin
              three_phase <= 1'b0;
              state       <= S_CHECK;
            end else if (!hi_phase) begin
              hi_phase <= 1'b1;
            end else begin
              hi_phase <= 1'b0;
              state    <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= sq_over ? S_DONE : S_DIV;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: candidate, wheel position, square and running verdict.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        n       <= candidate;
        verdict <= (candidate == NUMBER_WIDTH'(PAIR_GAP)) ||
                   (candidate == NUMBER_WIDTH'(SMALL_PRIME));
      end
      S_DIV: begin
        if (div_st.done) begin
          if (div_st.rem_zero) begin
            verdict <= 1'b0;
          end else if (three_phase) begin
            d  <= DW'(FIRST_DIVISOR);
            sq <= SW'(FIRST_DIVISOR * FIRST_DIVISOR);
          end
        end
      end
      S_STEP: begin
        // Advance the wheel: (d + 6)^2 = d^2 + 8d + 4d + 36.
        d  <= d + DW'(WHEEL_STEP);
        sq <= sq + SW'({d, 3'b000}) + SW'({d, 2'b00}) + SW'(SQ_STEP_CONST);
      end
      S_CHECK: begin
        if (sq_over) begin
          verdict <= 1'b1;
        end
      end
      S_DONE: begin
        verdict <= verdict;
      end
      default: begin
        verdict <= verdict;
      end
    endcase
  end

  // Output register: load when the verdict is ready and the slot is free; drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      is_prime <= verdict;
    end
  end

  tdp_div #(
    .NUMBER_WIDTH  (NUMBER_WIDTH),
    .DIVISOR_WIDTH (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st)
  );

endmodule

[design/tdp_checker.sv]
module tdp_checker #(
  parameter int NUMBER_WIDTH = 20
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [NUMBER_WIDTH-1:0] candidate,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    is_prime
);

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_prime))
    else $error("result changed or vanished while stalled");

  // One request in flight: accepting a request closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a request was accepted");

  // A new result only shows up while a request is being worked on.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with no request in flight");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Candidates 2 and 3 take the short path: input closes, then the result comes out as prime.
  a_small_prime: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid &&
    (candidate == NUMBER_WIDTH'(2) || candidate == NUMBER_WIDTH'(3))
    |=> ##1 out_valid && is_prime)
    else $error("small prime not reported as prime");

endmodule

bind trial_division_prime_test_unit tdp_checker #(
  .NUMBER_WIDTH (NUMBER_WIDTH)
) u_tdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .candidate (candidate),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .is_prime  (is_prime)
);
